// ===== hw/rtl/htmlesc_pkg.sv =====
// Shared types and character codes for the HTML entity escaper.
package htmlesc_pkg;

  localparam int unsigned RunMax   = 6;
  localparam int unsigned RunIdxW  = $clog2(RunMax);
  localparam int unsigned RunLenW  = $clog2(RunMax + 1);

  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChCtlMax = 8'h1F;
  localparam logic [7:0] ChDel    = 8'h7F;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChQuot   = 8'h22;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChAmp    = 8'h26;
  localparam logic [7:0] ChApos   = 8'h27;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChThree  = 8'h33;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChLess   = 8'h3C;
  localparam logic [7:0] ChGreat  = 8'h3E;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowG   = 8'h67;
  localparam logic [7:0] ChLowL   = 8'h6C;
  localparam logic [7:0] ChLowM   = 8'h6D;
  localparam logic [7:0] ChLowO   = 8'h6F;
  localparam logic [7:0] ChLowP   = 8'h70;
  localparam logic [7:0] ChLowQ   = 8'h71;
  localparam logic [7:0] ChLowT   = 8'h74;
  localparam logic [7:0] ChLowU   = 8'h75;

  typedef enum logic [2:0] {
    CLS_PLAIN,
    CLS_LT,
    CLS_GT,
    CLS_QUOT,
    CLS_AMP,
    CLS_APOS,
    CLS_NUM
  } char_cls_e;

  typedef logic [RunMax-1:0][7:0] run_bytes_t;

endpackage

// ===== hw/rtl/html_entity_escaper_unit.sv =====
// HTML entity escaper: classify, digit split, run build and byte serialiser.
// Throughput: one byte per cycle; busy_o holds the whole pipeline while the serialiser
// is inside a run, and drops on that run's last byte.
// Reset clears all valid bits and the serialiser index; no result follows reset.
// The receiver cannot stall: out_valid_o marks each byte for exactly one cycle.
module html_entity_escaper_unit
  import htmlesc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       busy_o,
  output logic       out_valid_o,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       string_end_o
);

  // stage 1: input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  // stage 2: class, hundreds digit and remainder
  logic       s2_valid_q;
  char_cls_e  s2_cls_q, s2_cls_d;
  logic [7:0] s2_byte_q;
  logic       s2_last_q;
  logic [1:0] s2_hund_q, s2_hund_d;
  logic [6:0] s2_rem_q, s2_rem_d;
  logic       s2_ge10_q;
  logic       s2_ge100_q;

  // stage 3: run held in the serialiser
  logic               s3_valid_q;
  run_bytes_t         s3_run_q, s3_run_d;
  logic [RunLenW-1:0] s3_len_q, s3_len_d;
  logic [RunIdxW-1:0] s3_idx_q;
  logic               s3_last_q;

  logic               hold;
  logic               advance;
  logic               run_end;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       run_last_q;
  logic       string_end_q;

  assign run_end = (RunLenW'(s3_idx_q) == s3_len_q - RunLenW'(1));
  assign hold    = s3_valid_q && !run_end;
  assign advance = !hold;
  assign busy_o  = hold;

  // classify and split off the hundreds digit
  always_comb begin
    logic [7:0] rem8;
    rem8 = s1_byte_q;
    s2_hund_d = 2'd0;
    if (s1_byte_q >= 8'd200) begin
      s2_hund_d = 2'd2;
      rem8 = s1_byte_q - 8'd200;
    end else if (s1_byte_q >= 8'd100) begin
      s2_hund_d = 2'd1;
      rem8 = s1_byte_q - 8'd100;
    end
    s2_rem_d = rem8[6:0];
    case (s1_byte_q)
      ChLess:  s2_cls_d = CLS_LT;
      ChGreat: s2_cls_d = CLS_GT;
      ChQuot:  s2_cls_d = CLS_QUOT;
      ChAmp:   s2_cls_d = CLS_AMP;
      ChApos:  s2_cls_d = CLS_APOS;
      ChTab, ChNl, ChCr: s2_cls_d = CLS_PLAIN;
      default: begin
        if (s1_byte_q <= ChCtlMax || s1_byte_q >= ChDel) begin
          s2_cls_d = CLS_NUM;
        end else begin
          s2_cls_d = CLS_PLAIN;
        end
      end
    endcase
  end

  // tens and units by reciprocal multiply, then build the run
  always_comb begin
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [6:0]  units;
    prod     = 15'(s2_rem_q) * 15'd205;
    tens     = prod[14:11];
    tens_x10 = 7'(tens) * 7'd10;
    units    = s2_rem_q - tens_x10;
    s3_run_d = '0;
    s3_len_d = RunLenW'(1);
    case (s2_cls_q)
      CLS_LT: begin
        s3_run_d[0] = ChAmp;  s3_run_d[1] = ChLowL;
        s3_run_d[2] = ChLowT; s3_run_d[3] = ChSemi;
        s3_len_d = RunLenW'(4);
      end
      CLS_GT: begin
        s3_run_d[0] = ChAmp;  s3_run_d[1] = ChLowG;
        s3_run_d[2] = ChLowT; s3_run_d[3] = ChSemi;
        s3_len_d = RunLenW'(4);
      end
      CLS_QUOT: begin
        s3_run_d[0] = ChAmp;  s3_run_d[1] = ChLowQ;
        s3_run_d[2] = ChLowU; s3_run_d[3] = ChLowO;
        s3_run_d[4] = ChLowT; s3_run_d[5] = ChSemi;
        s3_len_d = RunLenW'(6);
      end
      CLS_AMP: begin
        s3_run_d[0] = ChAmp;  s3_run_d[1] = ChLowA;
        s3_run_d[2] = ChLowM; s3_run_d[3] = ChLowP;
        s3_run_d[4] = ChSemi;
        s3_len_d = RunLenW'(5);
      end
      CLS_APOS: begin
        s3_run_d[0] = ChAmp;   s3_run_d[1] = ChHash;
        s3_run_d[2] = ChThree; s3_run_d[3] = ChNine;
        s3_run_d[4] = ChSemi;
        s3_len_d = RunLenW'(5);
      end
      CLS_NUM: begin
        s3_run_d[0] = ChAmp;
        s3_run_d[1] = ChHash;
        s3_run_d[2] = s2_ge100_q ? (ChZero + 8'(s2_hund_q)) : ChSpace;
        s3_run_d[3] = s2_ge10_q ? (ChZero + 8'(tens)) : ChSpace;
        s3_run_d[4] = ChZero + 8'(units);
        s3_run_d[5] = ChSemi;
        s3_len_d = RunLenW'(6);
      end
      default: begin
        s3_run_d[0] = s2_byte_q;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s3_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= s3_valid_q;
      if (advance) begin
        s1_valid_q <= start_i;
        s2_valid_q <= s1_valid_q;
        s3_valid_q <= s2_valid_q;
        s3_idx_q   <= '0;
      end else begin
        s3_idx_q <= s3_idx_q + RunIdxW'(1);
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    out_byte_q   <= s3_run_q[s3_idx_q];
    run_last_q   <= run_end;
    string_end_q <= run_end && s3_last_q;
    if (advance) begin
      s1_byte_q  <= in_byte_i;
      s1_last_q  <= in_last_i;
      s2_cls_q   <= s2_cls_d;
      s2_byte_q  <= s1_byte_q;
      s2_last_q  <= s1_last_q;
      s2_hund_q  <= s2_hund_d;
      s2_rem_q   <= s2_rem_d;
      s2_ge10_q  <= (s1_byte_q >= 8'd10);
      s2_ge100_q <= (s1_byte_q >= 8'd100);
      s3_run_q   <= s3_run_d;
      s3_len_q   <= s3_len_d;
      s3_last_q  <= s2_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign run_last_o   = run_last_q;
  assign string_end_o = string_end_q && out_valid_q;

  a_busy_emits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> out_valid_o)
    else $error("busy without a byte strobed next cycle");

  a_run_contiguous : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_last_o |=> out_valid_o)
    else $error("run broken before its last byte");

  a_end_on_run_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    string_end_o |-> out_valid_o && run_last_o)
    else $error("string end outside a run's last byte");

endmodule

// ===== dv/escaper_checker.sv =====
// Checker for the HTML entity escaper: predicts each escaped run and compares every byte.
module escaper_checker
  import htmlesc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       busy_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       out_valid_i,
  input  logic [7:0] out_byte_i,
  input  logic       run_last_i,
  input  logic       string_end_i,
  output int         errors_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       str_end;
  } esc_beat_t;

  esc_beat_t expected_beats [$];
  int        mismatches = 0;

  function automatic char_cls_e classify_char(logic [7:0] ch);
    char_cls_e cls;
    case (ch)
      ChLess:  cls = CLS_LT;
      ChGreat: cls = CLS_GT;
      ChQuot:  cls = CLS_QUOT;
      ChAmp:   cls = CLS_AMP;
      ChApos:  cls = CLS_APOS;
      default: begin
        if ((ch <= ChCtlMax || ch >= ChDel) && ch != ChTab && ch != ChNl && ch != ChCr)
          cls = CLS_NUM;
        else
          cls = CLS_PLAIN;
      end
    endcase
    return cls;
  endfunction

  task automatic predict_escape(logic [7:0] ch, logic str_last);
    logic [7:0] seq [$];
    logic [7:0] hundreds;
    logic [7:0] tens;
    logic [7:0] ones;
    esc_beat_t  beat;
    hundreds = (ch >= 8'd100) ? ChZero + ch / 8'd100 : ChSpace;
    tens     = (ch >= 8'd10) ? ChZero + (ch / 8'd10) % 8'd10 : ChSpace;
    ones     = ChZero + ch % 8'd10;
    case (classify_char(ch))
      CLS_LT:   seq = '{ChAmp, ChLowL, ChLowT, ChSemi};
      CLS_GT:   seq = '{ChAmp, ChLowG, ChLowT, ChSemi};
      CLS_QUOT: seq = '{ChAmp, ChLowQ, ChLowU, ChLowO, ChLowT, ChSemi};
      CLS_AMP:  seq = '{ChAmp, ChLowA, ChLowM, ChLowP, ChSemi};
      CLS_APOS: seq = '{ChAmp, ChHash, ChThree, ChNine, ChSemi};
      CLS_NUM:  seq = '{ChAmp, ChHash, hundreds, tens, ones, ChSemi};
      default:  seq = '{ch};
    endcase
    foreach (seq[k]) begin
      beat.data    = seq[k];
      beat.run_end = (k == seq.size() - 1);
      beat.str_end = (k == seq.size() - 1) && str_last;
      expected_beats.push_back(beat);
    end
  endtask

  always @(posedge clk_i) begin
    esc_beat_t want;
    if (rst_ni) begin
      if (out_valid_i) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected output byte %h with no transfer pending", out_byte_i);
          mismatches++;
        end else begin
          want = expected_beats.pop_front();
          if (out_byte_i !== want.data) begin
            $error("out_byte: expected %h, got %h", want.data, out_byte_i);
            mismatches++;
          end
          if (run_last_i !== want.run_end) begin
            $error("run_last: expected %b, got %b", want.run_end, run_last_i);
            mismatches++;
          end
          if (string_end_i !== want.str_end) begin
            $error("string_end: expected %b, got %b", want.str_end, string_end_i);
            mismatches++;
          end
        end
      end
      if (start_i && !busy_i)
        predict_escape(in_byte_i, in_last_i);
    end
    errors_o  <= mismatches;
    pending_o <= expected_beats.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the HTML entity escaper: clock, reset, byte stimulus and verdict.
module tb_top;
  import htmlesc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned ItemsPerPhase = 130;

  logic       clk_i;
  logic       rst_ni     = 1'b0;
  logic       start_i    = 1'b0;
  logic [7:0] in_byte_i  = 8'h00;
  logic       in_last_i  = 1'b0;
  logic       busy_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       run_last_o;
  logic       string_end_o;
  int         errors;
  int         pending;
  int         quiet_cycles = 0;

  html_entity_escaper_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .busy_o       (busy_o),
    .out_valid_o  (out_valid_o),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .string_end_o (string_end_o)
  );

  escaper_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .out_valid_i  (out_valid_o),
    .out_byte_i   (out_byte_o),
    .run_last_i   (run_last_o),
    .string_end_i (string_end_o),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || out_valid_o)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] ch, logic str_last, int unsigned idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    start_i   <= 1'b1;
    in_byte_i <= ch;
    in_last_i <= str_last;
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_char();
    logic [7:0] specials [] = '{ChLess, ChGreat, ChQuot, ChAmp, ChApos,
                                ChTab, ChNl, ChCr, 8'h00, ChCtlMax, ChDel, 8'hFF};
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 45)
      return 8'($urandom_range(8'h20, 8'h7E));
    else if (roll < 70)
      return specials[$urandom_range(specials.size() - 1)];
    else
      return 8'($urandom_range(255));
  endfunction

  task automatic send_strings(int unsigned count, int unsigned idle_pct);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 12);
      for (int unsigned k = 0; k < len; k++)
        send_byte(pick_char(), k == len - 1, idle_pct);
      sent += len;
      if ($urandom_range(19) == 0)
        drain_results();
    end
  endtask

  initial begin
    logic [7:0] directed [];
    directed = '{8'h00, ChTab, ChNl, ChCr, 8'h0B, ChCtlMax, ChSpace,
                 ChLess, ChGreat, ChQuot, ChAmp, ChApos, 8'h41, 8'h7E,
                 ChDel, 8'h80, 8'd99, 8'd100, 8'hFF, 8'h61};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[k])
      send_byte(directed[k], (k % 4 == 3) || (k == directed.size() - 1), 0);
    send_byte(8'h00, 1'b1, 0);
    send_byte(ChSpace, 1'b1, 0);
    send_byte(ChNine, 1'b1, 0);
    drain_results();

    send_strings(ItemsPerPhase, 30);
    drain_results();
    send_strings(ItemsPerPhase, 48);
    drain_results();
    send_strings(ItemsPerPhase, 0);

    drain_results();
    repeat (8) @(posedge clk_i);
    if (errors == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
